// ===== rtl/pitm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_pkg: shared types and constants of the PCI ID table matcher
// Holds the stored entry layout, the opcodes, the controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pitm_pkg;

   // Wildcards held in an entry field
   localparam logic [15:0] WILD16 = 16'hFFFF;
   localparam logic [7:0]  WILD8  = 8'd255;

   // Largest slot count that the 4-bit entry index can reach
   localparam int unsigned INDEX_REACH = 16;

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } pitm_opcode_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } pitm_state_type;

   // One table entry: identifiers, class bytes and match-mode flags
   typedef struct packed {
      logic        class_only;
      logic        advanced;
      logic        simple_class;
      logic        simple;
      logic [7:0]  prog_if;
      logic [7:0]  sub_class;
      logic [7:0]  base_class;
      logic [15:0] sub_vendor;
      logic [15:0] vendor;
      logic [15:0] device;
   } pitm_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic write_en;     // store the request as a table entry
      logic load_lookup;  // capture the lookup fields
      logic clear_count;  // scan pointer to slot 0
      logic step_count;   // scan pointer to next slot
      logic set_result;   // load the result register
      logic result_hit;   // result carries a hit at the scan pointer
   } pitm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic entry_match;  // entry under the pointer matches
      logic entry_term;   // entry under the pointer is a terminator
      logic scan_last;    // pointer is at the last reachable slot
   } pitm_status_type;

endpackage
`default_nettype wire

// ===== rtl/pitm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_datapath: entry store, scan pointer, compare and result register
// Entries live in flip-flops with one valid bit each; an unwritten slot reads
// as all zero. One entry is compared per cycle at the scan pointer.
// ----------------------------------------------------------------------------
module pitm_datapath #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pitm_pkg::pitm_cmd_type cmd,
   output pitm_pkg::pitm_status_type   status,
   input  wire logic [3:0]             req_entry_index,
   input  wire logic [15:0]            req_device_ident,
   input  wire logic [15:0]            req_vendor_ident,
   input  wire logic [15:0]            req_sub_vendor_ident,
   input  wire logic [7:0]             req_base_class_code,
   input  wire logic [7:0]             req_sub_class_code,
   input  wire logic [7:0]             req_prog_interface,
   input  wire logic                   req_simple_flag,
   input  wire logic                   req_simple_class_flag,
   input  wire logic                   req_advanced_flag,
   input  wire logic                   req_class_only_flag,
   output logic                        rsp_hit,
   output logic [3:0]                  rsp_match_index
);

   // Only the first sixteen slots can ever be written
   localparam int unsigned STORE_DEPTH = (TABLE_DEPTH < pitm_pkg::INDEX_REACH) ?
                                         TABLE_DEPTH : pitm_pkg::INDEX_REACH;
   localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

   pitm_pkg::pitm_entry_type store_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0]   valid_ff;
   pitm_pkg::pitm_entry_type look_ff;
   pitm_pkg::pitm_entry_type wr_entry;
   pitm_pkg::pitm_entry_type rd_entry;
   logic [IDX_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]         cnt_in;
   logic                     hit_ff;
   logic [3:0]               index_ff;
   logic                     slot_ok;
   logic [IDX_W-1:0]         wr_idx;
   logic m_dev, m_ven, m_sven, m_b, m_s, m_p;
   logic full, simple, sclass, adv, cls;

   // Request packed into entry layout
   always_comb begin
      wr_entry.device       = req_device_ident;
      wr_entry.vendor       = req_vendor_ident;
      wr_entry.sub_vendor   = req_sub_vendor_ident;
      wr_entry.base_class   = req_base_class_code;
      wr_entry.sub_class    = req_sub_class_code;
      wr_entry.prog_if      = req_prog_interface;
      wr_entry.simple       = req_simple_flag;
      wr_entry.simple_class = req_simple_class_flag;
      wr_entry.advanced     = req_advanced_flag;
      wr_entry.class_only   = req_class_only_flag;
   end

   // Out-of-range writes are dropped
   assign slot_ok = ({1'b0, req_entry_index} < 5'(STORE_DEPTH));
   assign wr_idx  = req_entry_index[IDX_W-1:0];

   // Entry store
   always_ff @(posedge clock) begin
      if (cmd.write_en && slot_ok) begin
         store_ff[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_en && slot_ok) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // Lookup fields
   always_ff @(posedge clock) begin
      if (cmd.load_lookup) begin
         look_ff <= wr_entry;
      end
   end

   // Scan pointer
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_count) begin
         cnt_in = '0;
      end else if (cmd.step_count) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Entry under the pointer, unwritten slots read as zero
   assign rd_entry = valid_ff[cnt_ff] ? store_ff[cnt_ff] : '0;

   // Field compares with wildcard
   always_comb begin
      m_dev  = (rd_entry.device == look_ff.device) ||
               (rd_entry.device == pitm_pkg::WILD16);
      m_ven  = (rd_entry.vendor == look_ff.vendor) ||
               (rd_entry.vendor == pitm_pkg::WILD16);
      m_sven = (rd_entry.sub_vendor == look_ff.sub_vendor) ||
               (rd_entry.sub_vendor == pitm_pkg::WILD16);
      m_b    = (rd_entry.base_class == look_ff.base_class) ||
               (rd_entry.base_class == pitm_pkg::WILD8);
      m_s    = (rd_entry.sub_class == look_ff.sub_class) ||
               (rd_entry.sub_class == pitm_pkg::WILD8);
      m_p    = (rd_entry.prog_if == look_ff.prog_if) ||
               (rd_entry.prog_if == pitm_pkg::WILD8);
   end

   // Match modes
   always_comb begin
      full   = m_dev && m_ven && m_sven && m_b && m_s && m_p;
      simple = rd_entry.simple && m_dev && m_ven;
      sclass = rd_entry.simple_class && m_dev && m_ven && m_b && m_s;
      adv    = rd_entry.advanced && m_dev && m_ven && m_sven;
      cls    = rd_entry.class_only && m_b && m_s && m_p;
   end

   always_comb begin
      status.entry_match = full || simple || sclass || adv || cls;
      status.entry_term  = (rd_entry.vendor == '0) && (rd_entry.device == '0) &&
                           !rd_entry.class_only;
      status.scan_last   = (cnt_ff == IDX_W'(STORE_DEPTH - 1));
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         hit_ff   <= cmd.result_hit;
         index_ff <= cmd.result_hit ? 4'(cnt_ff) : 4'd0;
      end
   end

   assign rsp_hit         = hit_ff;
   assign rsp_match_index = index_ff;

endmodule
`default_nettype wire

// ===== rtl/pitm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_ctrl: request controller of the PCI ID table matcher
// Takes requests, steps the scan one slot a cycle and raises the result
// strobe for one cycle when an item is finished.
// ----------------------------------------------------------------------------
module pitm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      req_opcode,
   input  wire pitm_pkg::pitm_status_type status,
   output pitm_pkg::pitm_cmd_type         cmd,
   output logic                           busy,
   output logic                           rsp_valid
);

   pitm_pkg::pitm_state_type state_ff;
   pitm_pkg::pitm_state_type state_in;
   logic                     valid_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pitm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         pitm_pkg::ST_IDLE: begin
            if (start) begin
               if (req_opcode == pitm_pkg::OP_WRITE) begin
                  cmd.write_en   = 1'b1;
                  cmd.set_result = 1'b1;
               end else begin
                  cmd.load_lookup = 1'b1;
                  cmd.clear_count = 1'b1;
                  state_in        = pitm_pkg::ST_SCAN;
               end
            end
         end
         pitm_pkg::ST_SCAN: begin
            busy = 1'b1;
            if (status.entry_match) begin
               cmd.set_result = 1'b1;
               cmd.result_hit = 1'b1;
               state_in       = pitm_pkg::ST_IDLE;
            end else if (status.entry_term || status.scan_last) begin
               cmd.set_result = 1'b1;
               state_in       = pitm_pkg::ST_IDLE;
            end else begin
               cmd.step_count = 1'b1;
            end
         end
         default: begin
            state_in = pitm_pkg::ST_IDLE;
         end
      endcase
   end

   // Result strobe follows the result register load
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.set_result;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/pci_id_table_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pci_id_table_matcher: device-match table with first-hit lookup
// Write items store one match entry; lookup items scan the table upward from
// slot 0 and return the first matching slot.
//
//   channel   handshake           payload
//   request   start / busy        req_opcode .. req_class_only_flag
//   result    rsp_valid strobe    rsp_hit, rsp_match_index
//
// A write item's result strobes in the cycle after accept.
// A lookup compares one slot per cycle in the scan loop; its result strobes
// once the scan stops on a match, a terminator or the last reachable slot; busy is high meanwhile.
// Reset clears the controller and the per-slot valid bits at once, so every
// slot reads as zero; no clearing pass is needed.
// The receiver cannot stall: each result stands for exactly one cycle, and a
// new item may be accepted in the cycle its predecessor's result shows.
// ----------------------------------------------------------------------------
module pci_id_table_matcher #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [15:0] req_device_ident,
   input  wire logic [15:0] req_vendor_ident,
   input  wire logic [15:0] req_sub_vendor_ident,
   input  wire logic [7:0]  req_base_class_code,
   input  wire logic [7:0]  req_sub_class_code,
   input  wire logic [7:0]  req_prog_interface,
   input  wire logic        req_simple_flag,
   input  wire logic        req_simple_class_flag,
   input  wire logic        req_advanced_flag,
   input  wire logic        req_class_only_flag,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [3:0]       rsp_match_index
);

   pitm_pkg::pitm_cmd_type    cmd;
   pitm_pkg::pitm_status_type status;

   // Controller
   pitm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   // Datapath
   pitm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_entry_index       (req_entry_index),
      .req_device_ident      (req_device_ident),
      .req_vendor_ident      (req_vendor_ident),
      .req_sub_vendor_ident  (req_sub_vendor_ident),
      .req_base_class_code   (req_base_class_code),
      .req_sub_class_code    (req_sub_class_code),
      .req_prog_interface    (req_prog_interface),
      .req_simple_flag       (req_simple_flag),
      .req_simple_class_flag (req_simple_class_flag),
      .req_advanced_flag     (req_advanced_flag),
      .req_class_only_flag   (req_class_only_flag),
      .rsp_hit               (rsp_hit),
      .rsp_match_index       (rsp_match_index)
   );

   // A write item is answered in the very next cycle
   a_write_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == pitm_pkg::OP_WRITE)) |=> rsp_valid)
      else $error("write item not answered next cycle");

   // A lookup item holds the request side off while it scans
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == pitm_pkg::OP_LOOKUP)) |=> (busy && !rsp_valid))
      else $error("lookup did not enter scan");

   // A result always leaves the block ready for the next item
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // A miss carries slot zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_match_index == 4'd0))
      else $error("miss with nonzero index");

endmodule
`default_nettype wire
